@@ rtl/socket_rule_first_match_classifier_defines.svh @@
// Assertion macros for the socket rule classifier.
`ifndef SOCKET_RULE_FIRST_MATCH_CLASSIFIER_DEFINES_SVH
`define SOCKET_RULE_FIRST_MATCH_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SRFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srfm: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define SRFM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srfm: next-cycle check failed");

`endif

@@ rtl/srfm_pkg.sv @@
// Shared types, constants and helpers of the socket rule classifier.
package srfm_pkg;

    localparam int RULE_SLOTS_DEF = 16;

    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Command kinds carried on tuser
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    // Call classes
    localparam logic [1:0] CLS_CLIENT = 2'd0;
    localparam logic [1:0] CLS_SERVER = 2'd1;

    // Option bit positions
    localparam int OPT_UID     = 0;
    localparam int OPT_PROTO   = 1;
    localparam int OPT_LIP     = 2;
    localparam int OPT_LMASK   = 3;
    localparam int OPT_RIP     = 4;
    localparam int OPT_RMASK   = 5;
    localparam int OPT_LPORT   = 6;
    localparam int OPT_RPORT   = 7;
    localparam int OPT_CLIENT  = 8;
    localparam int OPT_SERVER  = 9;
    localparam int OPT_STRICT  = 10;
    localparam int OPT_INHERIT = 11;

    // A rule with none of these bits set never takes part in a lookup
    localparam logic [11:0] OPT_SOCKET_ANY = 12'h3FE;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] options;
        logic [31:0] uid;
        logic [15:0] proto;
        logic [31:0] laddr;
        logic [31:0] lmask;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [31:0] rmask;
        logic [15:0] rport;
    } t_rule;

    typedef struct packed {
        logic [31:0] uid;
        logic [15:0] proto;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic [1:0]  cls;
    } t_call;

    typedef struct packed {
        logic       full;
        logic [3:0] index;
        logic       inherit;
        logic       inode;
        logic [1:0] action;
        logic       matched;
    } t_result;

    // Prefix length to network mask; zero gives no mask, 32 and above a full one
    function automatic logic [31:0] prefix_to_mask(input logic [5:0] len);
        logic [31:0] mask;
        if (len == 6'd0) begin
            mask = 32'h0;
        end else if (len >= 6'd32) begin
            mask = 32'hFFFF_FFFF;
        end else begin
            mask = ~(32'hFFFF_FFFF >> len);
        end
        return mask;
    endfunction

endpackage

@@ rtl/srfm_rule_ram.sv @@
// Rule table storage: one write port, one registered read port.
module srfm_rule_ram #(
    parameter int DEPTH = srfm_pkg::RULE_SLOTS_DEF,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  srfm_pkg::t_rule i_wr_rule,
    input  logic [AW-1:0]   i_rd_addr,
    output srfm_pkg::t_rule o_rd_rule
);
    import srfm_pkg::*;

    t_rule r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_rule <= r_mem[i_rd_addr];
    end

endmodule

@@ rtl/srfm_rule_match.sv @@
// Compare unit: tests one stored rule against one socket call.
module srfm_rule_match (
    input  srfm_pkg::t_rule i_rule,
    input  srfm_pkg::t_call i_call,
    output logic            o_hit
);
    import srfm_pkg::*;

    logic [11:0] opt;
    logic        dir_ok;
    logic        uid_ok;
    logic        proto_ok;
    logic        lip_ok;
    logic        rip_ok;
    logic        lport_ok;
    logic        rport_ok;

    always_comb begin
        opt = i_rule.options;

        dir_ok = (!opt[OPT_CLIENT] || (i_call.cls == CLS_CLIENT))
              && (!opt[OPT_SERVER] || (i_call.cls == CLS_SERVER));

        uid_ok   = !opt[OPT_UID]   || (i_rule.uid == i_call.uid);
        proto_ok = !opt[OPT_PROTO] || (i_rule.proto == i_call.proto);

        // Mask bit counts only with its address bit
        if (!opt[OPT_LIP]) begin
            lip_ok = 1'b1;
        end else if (opt[OPT_LMASK]) begin
            lip_ok = ((i_rule.laddr ^ i_call.laddr) & i_rule.lmask) == 32'h0;
        end else begin
            lip_ok = (i_rule.laddr == i_call.laddr);
        end

        if (!opt[OPT_RIP]) begin
            rip_ok = 1'b1;
        end else if (opt[OPT_RMASK]) begin
            rip_ok = ((i_rule.raddr ^ i_call.raddr) & i_rule.rmask) == 32'h0;
        end else begin
            rip_ok = (i_rule.raddr == i_call.raddr);
        end

        lport_ok = !opt[OPT_LPORT] || (i_rule.lport == i_call.lport);
        rport_ok = !opt[OPT_RPORT] || (i_rule.rport == i_call.rport);

        o_hit = ((opt & OPT_SOCKET_ANY) != 12'h0) && dir_ok && uid_ok && proto_ok
             && lip_ok && rip_ok && lport_ok && rport_ok;
    end

endmodule

@@ rtl/socket_rule_first_match_classifier.sv @@
// Top level of the first-match socket rule classifier.
//
// Usage: commands enter on the slave stream (i_s_*); each one gives exactly one
// result transfer on the master stream (o_m_*). tuser selects the command:
// clear the table, append one rule at its end, or look up one socket call.
// A lookup scans the stored rules in order and reports the first rule whose
// enabled tests all pass, with its action, strict and inherit flags and index.
//
// Sequence: clear, append and unused kinds go straight to the result state,
// and the block is ready again once the result is loaded into the output
// register. A lookup reads the stored rules from the table RAM in order and
// checks each registered rule while the next read is issued; it stops at the
// first hit or after the last stored rule. One rule is read from the table
// RAM and compared each cycle, so the single read port sets the scan speed.
// The block takes one command at a time: o_s_tready is high only while idle.
//
// Reset (synchronous, active low) empties the table and drops any pending
// result. When the receiver stalls, the output register holds its transfer;
// the block still accepts the next command, and a later result waits inside
// until the output register frees.
`include "socket_rule_first_match_classifier_defines.svh"

module socket_rule_first_match_classifier #(
    parameter int RULE_SLOTS = srfm_pkg::RULE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // rule_action, rule_options, user_id, protocol, local_addr, local_prefix,
    // local_port_num, remote_addr, remote_prefix, remote_port_num, call_class,
    // zero pad (lowest bit first)
    input  logic [srfm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // kind
    input  logic [srfm_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // matched, match_action, mark_inode, mark_inherit, match_index, table_full,
    // zero pad (lowest bit first)
    output logic [srfm_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import srfm_pkg::*;

    localparam int CW = $clog2(RULE_SLOTS + 1);
    localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]  r_state,   n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan,  n_scan;
    logic        r_chk_vld, n_chk_vld;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    t_call       r_call,    n_call;
    t_result     r_res,     n_res;

    logic        s_accept;
    logic [1:0]  in_kind;
    t_call       in_call;
    t_rule       in_rule;
    logic        tbl_full;
    logic        wr_en;
    logic        issue;
    t_rule       rd_rule;
    logic        hit;
    logic        out_free;

    // Unpack the slave transfer
    always_comb begin
        in_kind = i_s_tuser[1:0];

        in_rule.action  = i_s_tdata[1:0];
        in_rule.options = i_s_tdata[13:2];
        in_rule.uid     = i_s_tdata[45:14];
        in_rule.proto   = i_s_tdata[61:46];
        in_rule.laddr   = i_s_tdata[93:62];
        in_rule.lmask   = prefix_to_mask(i_s_tdata[99:94]);
        in_rule.lport   = i_s_tdata[115:100];
        in_rule.raddr   = i_s_tdata[147:116];
        in_rule.rmask   = prefix_to_mask(i_s_tdata[153:148]);
        in_rule.rport   = i_s_tdata[169:154];

        in_call.uid   = i_s_tdata[45:14];
        in_call.proto = i_s_tdata[61:46];
        in_call.laddr = i_s_tdata[93:62];
        in_call.lport = i_s_tdata[115:100];
        in_call.raddr = i_s_tdata[147:116];
        in_call.rport = i_s_tdata[169:154];
        in_call.cls   = i_s_tdata[171:170];
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign tbl_full   = (r_count == CW'(RULE_SLOTS));
    assign wr_en      = s_accept && (in_kind == KIND_APPEND) && !tbl_full;
    assign issue      = (r_state == ST_SCAN) && (r_scan < r_count);
    assign out_free   = !o_m_tvalid || i_m_tready;

    srfm_rule_ram #(
        .DEPTH (RULE_SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_rule (in_rule),
        .i_rd_addr (r_scan[IW-1:0]),
        .o_rd_rule (rd_rule)
    );

    srfm_rule_match u_match (
        .i_rule (rd_rule),
        .i_call (r_call),
        .o_hit  (hit)
    );

    // Sequencer: idle, scan one rule per cycle, hand the result over
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_scan    = r_scan;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_call    = r_call;
        n_res     = r_res;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_res   = '0;
                    n_state = ST_RESULT;
                    unique case (in_kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        KIND_APPEND: begin
                            if (tbl_full) begin
                                n_res.full = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_LOOKUP: begin
                            n_call = in_call;
                            n_scan = '0;
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            // unused kind: all-zero result
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next read while the previous rule is checked
                if (issue) begin
                    n_scan    = r_scan + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_scan[IW-1:0];
                end
                if (r_chk_vld && hit) begin
                    n_res.matched = 1'b1;
                    n_res.action  = rd_rule.action;
                    n_res.inode   = rd_rule.options[OPT_STRICT];
                    n_res.inherit = rd_rule.options[OPT_INHERIT];
                    n_res.index   = 4'(r_chk_idx);
                    n_chk_vld     = 1'b0;
                    n_state       = ST_RESULT;
                end else if (r_chk_vld && (CW'(r_chk_idx) == r_count - 1'b1)) begin
                    n_chk_vld = 1'b0;
                    n_state   = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_scan    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_scan    <= n_scan;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_call    <= n_call;
        r_res     <= n_res;
    end

    // Output register: load the waiting result once the slot frees, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if ((r_state == ST_RESULT) && out_free) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RESULT) && out_free) begin
            o_m_tdata <= {(M_TDATA_W - $bits(t_result))'(0), r_res};
        end
    end

    // Checks
    `SRFM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(RULE_SLOTS))
    `SRFM_ASSERT_NOW(a_chk_in_table, i_clk, i_rst_n, r_chk_vld, CW'(r_chk_idx) < r_count)
    `SRFM_ASSERT_NXT(a_full_flag, i_clk, i_rst_n, s_accept && (in_kind == KIND_APPEND) && tbl_full, (r_state == ST_RESULT) && r_res.full && (r_count == CW'(RULE_SLOTS)))
    `SRFM_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, s_accept && (in_kind == KIND_CLEAR), r_count == '0)

endmodule

@@ dv/tb_socket_rule_first_match_classifier.sv @@
`timescale 1ns / 1ps
// Stream-level testbench for the first-match socket rule classifier.
module tb_socket_rule_first_match_classifier;
    import srfm_pkg::*;

    // Kind and call-class codes not named in the shared package
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [1:0] CLS_OTHER = 2'd2;
    localparam logic [1:0] CLS_ODD   = 2'd3;

    // Rule actions
    localparam logic [1:0] ACT_IGNORE   = 2'd0;
    localparam logic [1:0] ACT_KEYS     = 2'd1;
    localparam logic [1:0] ACT_FULL     = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Option masks built from the package bit positions
    localparam logic [11:0] B_UID     = 12'h1 << OPT_UID;
    localparam logic [11:0] B_PROTO   = 12'h1 << OPT_PROTO;
    localparam logic [11:0] B_LIP     = 12'h1 << OPT_LIP;
    localparam logic [11:0] B_LMASK   = 12'h1 << OPT_LMASK;
    localparam logic [11:0] B_RIP     = 12'h1 << OPT_RIP;
    localparam logic [11:0] B_RMASK   = 12'h1 << OPT_RMASK;
    localparam logic [11:0] B_LPORT   = 12'h1 << OPT_LPORT;
    localparam logic [11:0] B_RPORT   = 12'h1 << OPT_RPORT;
    localparam logic [11:0] B_CLIENT  = 12'h1 << OPT_CLIENT;
    localparam logic [11:0] B_SERVER  = 12'h1 << OPT_SERVER;
    localparam logic [11:0] B_STRICT  = 12'h1 << OPT_STRICT;
    localparam logic [11:0] B_INHERIT = 12'h1 << OPT_INHERIT;

    localparam int SLOTS        = RULE_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  act;
        logic [11:0] opts;
        logic [31:0] uid;
        logic [15:0] proto;
        logic [31:0] laddr;
        logic [5:0]  lpfx;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [5:0]  rpfx;
        logic [15:0] rport;
        logic [1:0]  cls;
    } t_sock_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // rule_action, rule_options, user_id, protocol, local_addr, local_prefix,
    // local_port_num, remote_addr, remote_prefix, remote_port_num, call_class, pad
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    // kind
    logic [S_TUSER_W-1:0] i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // matched, match_action, mark_inode, mark_inherit, match_index, table_full, pad
    logic [M_TDATA_W-1:0] o_m_tdata;

    socket_rule_first_match_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Commands waiting to be sent, and verdicts waiting for their transfer
    t_sock_cmd cmd_q[$];
    t_result   verdict_q[$];
    t_sock_cmd listed_rules[$];  // rules the generator believes are in the table

    int mismatch_count = 0;
    int sent_count = 0;
    int tail_mark = 0;

    // Classifier image: rule table and fill level
    logic [1:0]  tbl_act   [SLOTS];
    logic [11:0] tbl_opts  [SLOTS];
    logic [31:0] tbl_uid   [SLOTS];
    logic [15:0] tbl_proto [SLOTS];
    logic [31:0] tbl_laddr [SLOTS];
    logic [31:0] tbl_lmask [SLOTS];
    logic [15:0] tbl_lport [SLOTS];
    logic [31:0] tbl_raddr [SLOTS];
    logic [31:0] tbl_rmask [SLOTS];
    logic [15:0] tbl_rport [SLOTS];
    int          tbl_used = 0;

    function automatic logic [31:0] prefix_mask(logic [5:0] len);
        if (len == 6'd0) return 32'h0;
        if (len >= 6'd32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic bit addr_pass(bit test, bit masked, logic [31:0] rule_a,
                                     logic [31:0] mask, logic [31:0] call_a);
        if (!test) return 1'b1;
        if (masked) return ((rule_a ^ call_a) & mask) == 32'h0;
        return rule_a == call_a;
    endfunction

    function automatic bit rule_hits(int k, t_sock_cmd c);
        logic [11:0] o;
        o = tbl_opts[k];
        if ((o & OPT_SOCKET_ANY) == 12'h0) return 1'b0;
        if (o[OPT_CLIENT] && c.cls != CLS_CLIENT) return 1'b0;
        if (o[OPT_SERVER] && c.cls != CLS_SERVER) return 1'b0;
        if (o[OPT_UID] && tbl_uid[k] != c.uid) return 1'b0;
        if (o[OPT_PROTO] && tbl_proto[k] != c.proto) return 1'b0;
        if (!addr_pass(o[OPT_LIP], o[OPT_LMASK], tbl_laddr[k], tbl_lmask[k], c.laddr))
            return 1'b0;
        if (!addr_pass(o[OPT_RIP], o[OPT_RMASK], tbl_raddr[k], tbl_rmask[k], c.raddr))
            return 1'b0;
        if (o[OPT_LPORT] && tbl_lport[k] != c.lport) return 1'b0;
        if (o[OPT_RPORT] && tbl_rport[k] != c.rport) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one command to the table image and return the result it should give
    function automatic t_result classify_cmd(t_sock_cmd c);
        t_result r;
        int      k;
        r = '0;
        case (c.kind)
            KIND_CLEAR: begin
                tbl_used = 0;
            end
            KIND_APPEND: begin
                if (tbl_used >= SLOTS) begin
                    r.full = 1'b1;
                end else begin
                    k = tbl_used;
                    tbl_act[k]   = c.act;
                    tbl_opts[k]  = c.opts;
                    tbl_uid[k]   = c.uid;
                    tbl_proto[k] = c.proto;
                    tbl_laddr[k] = c.laddr;
                    tbl_lmask[k] = prefix_mask(c.lpfx);
                    tbl_lport[k] = c.lport;
                    tbl_raddr[k] = c.raddr;
                    tbl_rmask[k] = prefix_mask(c.rpfx);
                    tbl_rport[k] = c.rport;
                    tbl_used     = k + 1;
                end
            end
            KIND_LOOKUP: begin
                for (k = 0; k < tbl_used; k++) begin
                    if (rule_hits(k, c)) begin
                        r.matched = 1'b1;
                        r.action  = tbl_act[k];
                        r.inode   = tbl_opts[k][OPT_STRICT];
                        r.inherit = tbl_opts[k][OPT_INHERIT];
                        r.index   = 4'(k);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_cmd(t_sock_cmd c);
        return {4'b0, c.cls, c.rport, c.rpfx, c.raddr, c.lport, c.lpfx, c.laddr,
                c.proto, c.uid, c.opts, c.act};
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 100) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic t_sock_cmd random_cmd();
        t_sock_cmd c;
        c.kind  = 2'($urandom_range(0, 3));
        c.act   = 2'($urandom);
        c.opts  = 12'($urandom);
        c.uid   = $urandom;
        c.proto = 16'($urandom);
        c.laddr = $urandom;
        c.lpfx  = 6'($urandom);
        c.lport = 16'($urandom);
        c.raddr = $urandom;
        c.rpfx  = 6'($urandom);
        c.rport = 16'($urandom);
        c.cls   = 2'($urandom);
        return c;
    endfunction

    function automatic t_sock_cmd mk_rule(logic [1:0] act, logic [11:0] opts,
                                          logic [31:0] uid, logic [15:0] proto,
                                          logic [31:0] laddr, logic [5:0] lpfx,
                                          logic [15:0] lport, logic [31:0] raddr,
                                          logic [5:0] rpfx, logic [15:0] rport);
        t_sock_cmd c;
        c = random_cmd();  // call class is unused on append, keep it random
        c.kind = KIND_APPEND;
        c.act = act; c.opts = opts; c.uid = uid; c.proto = proto;
        c.laddr = laddr; c.lpfx = lpfx; c.lport = lport;
        c.raddr = raddr; c.rpfx = rpfx; c.rport = rport;
        return c;
    endfunction

    function automatic t_sock_cmd mk_call(logic [31:0] uid, logic [15:0] proto,
                                          logic [31:0] laddr, logic [15:0] lport,
                                          logic [31:0] raddr, logic [15:0] rport,
                                          logic [1:0] cls);
        t_sock_cmd c;
        c = random_cmd();  // rule-only fields carry noise on a lookup
        c.kind = KIND_LOOKUP;
        c.uid = uid; c.proto = proto; c.laddr = laddr; c.lport = lport;
        c.raddr = raddr; c.rport = rport; c.cls = cls;
        return c;
    endfunction

    function automatic t_sock_cmd mk_bare(logic [1:0] kind);
        t_sock_cmd c;
        c = random_cmd();
        c.kind = kind;
        return c;
    endfunction

    // Random rule, biased away from rules that can never match
    function automatic t_sock_cmd random_rule();
        t_sock_cmd c;
        c = random_cmd();
        c.kind = KIND_APPEND;
        if ($urandom_range(0, 1) == 0) c.opts[OPT_SERVER] = 1'b0;
        if ($urandom_range(0, 3) != 0) begin
            c.lpfx = 6'($urandom_range(0, 32));
            c.rpfx = 6'($urandom_range(0, 32));
        end
        return c;
    endfunction

    // Lookup aimed at a listed rule, sometimes nudged off it by one bit
    function automatic t_sock_cmd aimed_call(t_sock_cmd r);
        t_sock_cmd   c;
        logic [31:0] m;
        c = mk_call(r.uid, r.proto, r.laddr, r.lport, r.raddr, r.rport, 2'($urandom));
        if (r.opts[OPT_LMASK]) begin
            m = prefix_mask(r.lpfx);
            c.laddr = (r.laddr & m) | ($urandom & ~m);
        end
        if (r.opts[OPT_RMASK]) begin
            m = prefix_mask(r.rpfx);
            c.raddr = (r.raddr & m) | ($urandom & ~m);
        end
        if (r.opts[OPT_CLIENT]) c.cls = CLS_CLIENT;
        else if (r.opts[OPT_SERVER]) c.cls = CLS_SERVER;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 6))
                0: c.uid[$urandom_range(0, 31)] ^= 1'b1;
                1: c.proto[$urandom_range(0, 15)] ^= 1'b1;
                2: c.laddr[$urandom_range(0, 31)] ^= 1'b1;
                3: c.raddr[$urandom_range(0, 31)] ^= 1'b1;
                4: c.lport[$urandom_range(0, 15)] ^= 1'b1;
                5: c.rport[$urandom_range(0, 15)] ^= 1'b1;
                default: c.cls = 2'($urandom);
            endcase
        end
        return c;
    endfunction

    task automatic enqueue(t_sock_cmd c);
        cmd_q.push_back(c);
        if (c.kind == KIND_CLEAR) listed_rules.delete();
        else if (c.kind == KIND_APPEND && listed_rules.size() < SLOTS) listed_rules.push_back(c);
    endtask

    task automatic build_stimulus();
        t_sock_cmd c;
        int        n;
        int        m;
        int        goal;

        // Directed: empty table, skipped rule, every test, special prefixes and classes
        enqueue(mk_bare(KIND_CLEAR));
        enqueue(mk_call(32'd1000, 16'd6, 32'h0, 16'd22, 32'h0A00_0001, 16'd80, CLS_CLIENT));
        enqueue(mk_rule(ACT_FULL, B_STRICT | B_INHERIT, 32'd1000, 16'd0, 32'h0, 6'd0,
                        16'd0, 32'h0, 6'd0, 16'd0));
        enqueue(mk_rule(ACT_RESERVED, B_UID | B_STRICT, 32'd1000, 16'd0, 32'h0, 6'd0,
                        16'd0, 32'h0, 6'd0, 16'd0));
        enqueue(mk_rule(ACT_KEYS, B_CLIENT | B_SERVER | B_PROTO, 32'd0, 16'd6, 32'h0, 6'd0,
                        16'd0, 32'h0, 6'd0, 16'd0));
        enqueue(mk_rule(ACT_FULL, B_LIP | B_LMASK | B_RIP | B_RMASK | B_INHERIT, 32'd0,
                        16'd0, 32'hDEAD_BEEF, 6'd0, 16'd0, 32'h0A00_0001, 6'd40, 16'd0));
        enqueue(mk_rule(ACT_IGNORE, B_LMASK | B_LPORT | B_SERVER, 32'd0, 16'd0,
                        32'h1234_5678, 6'd8, 16'd22, 32'h0, 6'd0, 16'd0));
        enqueue(mk_rule(ACT_KEYS, B_RIP | B_RPORT | B_UID | B_PROTO | B_LPORT | B_CLIENT,
                        32'hFFFF_FFFF, 16'hFFFF, 32'h0, 6'd63, 16'hFFFF, 32'hFFFF_FFFF,
                        6'd63, 16'hFFFF));
        enqueue(mk_call(32'd1000, 16'd0, 32'h0, 16'd0, 32'h0, 16'd0, CLS_OTHER));
        enqueue(mk_call(32'd0, 16'd6, 32'h0, 16'd0, 32'h0, 16'd0, CLS_CLIENT));
        enqueue(mk_call(32'd7, 16'd0, 32'h0, 16'd0, 32'h0A00_0001, 16'd0, CLS_ODD));
        enqueue(mk_call(32'd7, 16'd0, 32'hFFFF_FFFF, 16'd22, 32'h0, 16'd0, CLS_SERVER));
        c = mk_call(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                    16'hFFFF, CLS_CLIENT);
        c.act = ACT_RESERVED; c.opts = 12'hFFF; c.lpfx = 6'h3F; c.rpfx = 6'h3F;
        enqueue(c);
        c.kind = KIND_NONE; c.cls = CLS_ODD;
        enqueue(c);
        // Fill the table, then one append too many
        for (int k = 6; k <= SLOTS; k++)
            enqueue(mk_rule(2'(k), B_PROTO, 32'd0, 16'(100 + k), 32'h0, 6'd0, 16'd0,
                            32'h0, 6'd0, 16'd0));
        enqueue(mk_call(32'd5, 16'(100 + SLOTS - 1), 32'h0, 16'd0, 32'h0, 16'd0, CLS_OTHER));
        enqueue(mk_call(32'd5, 16'd9999, 32'h0, 16'd0, 32'h0, 16'd0, CLS_OTHER));
        enqueue(mk_bare(KIND_CLEAR));
        enqueue(mk_call(32'd1000, 16'd6, 32'h0, 16'd0, 32'h0, 16'd0, CLS_CLIENT));

        // Random: mostly fill-and-probe sequences, some raw noise
        goal = cmd_q.size() + RANDOM_ITEMS;
        while (cmd_q.size() < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                enqueue(random_cmd());
            end else begin
                if ($urandom_range(0, 3) != 0) enqueue(mk_bare(KIND_CLEAR));
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
                for (int k = 0; k < n; k++) enqueue(random_rule());
                m = $urandom_range(2, 10);
                for (int k = 0; k < m; k++) begin
                    if (listed_rules.size() > 0 && $urandom_range(0, 3) != 0)
                        enqueue(aimed_call(listed_rules[$urandom_range(0,
                                                      listed_rules.size() - 1)]));
                    else
                        enqueue(mk_call($urandom, 16'($urandom), $urandom, 16'($urandom),
                                        $urandom, 16'($urandom), 2'($urandom)));
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- idling

    // Alternate stretches with and without idling; none in the tail of the run
    logic idle_on = 1'b0;
    int   phase_left = 0;
    logic idle_ok;
    assign idle_ok = idle_on && (sent_count < tail_mark);

    always @(posedge i_clk) begin
        if (phase_left == 0) begin
            phase_left <= $urandom_range(30, 300);
            idle_on    <= ($urandom_range(0, 3) != 0);
        end else begin
            phase_left <= phase_left - 1;
        end
    end

    // ---------------------------------------------------------------- driver

    t_sock_cmd cur_cmd;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = i_s_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            gap_left   = 0;
        end else begin
            // Predict on the accepting edge, then drop valid unless refilled below
            if (i_s_tvalid && o_s_tready) begin
                verdict_q.push_back(classify_cmd(cur_cmd));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() > 0) begin
                    if (idle_ok && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(0, 7);
                    end else begin
                        cur_cmd = cmd_q.pop_front();
                        i_s_tdata  <= pack_cmd(cur_cmd);
                        i_s_tuser  <= cur_cmd.kind;
                        next_valid = 1'b1;
                        sent_count <= sent_count + 1;
                    end
                end
            end
        end
        i_s_tvalid <= next_valid;
    end

    // ---------------------------------------------------------------- receiver

    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing pending: %h",
                                          o_m_tdata));
            end else begin
                want = verdict_q.pop_front();
                check_field("matched", got.matched, want.matched);
                check_field("match_action", got.action, want.action);
                check_field("mark_inode", got.inode, want.inode);
                check_field("mark_inherit", got.inherit, want.inherit);
                check_field("match_index", got.index, want.index);
                check_field("table_full", got.full, want.full);
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        build_stimulus();
        tail_mark = cmd_q.size() * 7 / 8;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Hold until every command is taken and every result has come back
        while (cmd_q.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (verdict_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[socket_rule_first_match_classifier] OK");
        end else begin
            $display("[socket_rule_first_match_classifier] ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[socket_rule_first_match_classifier] ERROR");
        $finish;
    end

endmodule
